>>> hdl/qrmps_pkg.sv
// qr mask penalty scorer package: widths, rule constants, sequencer states
// no dependencies; used by qr_mask_penalty_scorer_core
`default_nettype none

package qrmps_pkg;

    localparam int MIN_SIDE     = 21;
    localparam int MAX_SIDE_DEF = 177;
    localparam int SIDE_W       = 8;
    localparam int RUN_W        = 8;
    localparam int HIST_W       = 11;

    localparam logic [HIST_W-1:0] FINDER_LEAD  = 11'h5D0;
    localparam logic [HIST_W-1:0] FINDER_TRAIL = 11'h05D;

    localparam int MIN_RUN       = 5;
    localparam int RUN_OFFSET    = 2;
    localparam int BLOCK_SCORE   = 3;
    localparam int PATTERN_SCORE = 40;

    localparam int PCT_FULL    = 100;
    localparam int PCT_HALF    = 50;
    localparam int PCT_STEP    = 5;
    localparam int STEP_COUNT  = PCT_FULL / PCT_STEP;
    localparam int HALF_STEPS  = PCT_HALF / PCT_STEP;
    localparam int STEP_SCORE  = 2 * PCT_STEP;
    localparam int Q_W         = $clog2(STEP_COUNT + 1);

    localparam int RUN_PEN_W     = 16;
    localparam int BLOCK_PEN_W   = 17;
    localparam int PATTERN_PEN_W = 22;
    localparam int BALANCE_PEN_W = 7;
    localparam int TOTAL_PEN_W   = 22;
    localparam int OUT_BITS      = RUN_PEN_W + BLOCK_PEN_W + PATTERN_PEN_W
                                   + BALANCE_PEN_W + TOTAL_PEN_W;
    localparam int OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int IN_DATA_W     = 8;

    typedef enum logic [1:0] {
        ST_SCAN,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> hdl/qr_mask_penalty_scorer_core.sv
// qr mask penalty scorer top level: column memory, row scan, balance divider
// depends on qrmps_pkg
`default_nettype none

// Scores one square QR symbol against the four mask penalty rules. Modules enter
// on s_axis one per transaction in raster order, one per clock cycle while
// s_axis_tready is high (it is low while a symbol closes and is scored); the
// only per-module storage is a column memory (run length and 11-bit history per
// column) that is read when a module is taken and written back in the cycle after.
// After the last module of a symbol the dark share is divided by the symbol area
// in a restoring divider, one quotient bit a cycle, and the result is then loaded
// into the output register; the next symbol may start while that result waits on
// m_axis. Writing side_size restarts the symbol; the column memory needs no clearing
// pass, since the first row of every symbol overwrites each column entry.
module qr_mask_penalty_scorer_core #(
    parameter int MAX_SIDE = qrmps_pkg::MAX_SIDE_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [qrmps_pkg::SIDE_W-1:0]    cfg_data,     // side_size
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [qrmps_pkg::IN_DATA_W-1:0] s_axis_tdata, // module_req, zero pad
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // run_penalty, block_penalty, pattern_penalty, balance_penalty, total_penalty,
    // zero pad
    output logic [qrmps_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int AW     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SQ_W   = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int DIV_W  = SQ_W + qrmps_pkg::Q_W;
    localparam int DARK_W = SQ_W;
    localparam int ENT_W  = qrmps_pkg::RUN_W + qrmps_pkg::HIST_W;
    localparam int SW     = qrmps_pkg::SIDE_W;
    localparam int RW     = qrmps_pkg::RUN_W;
    localparam int HW     = qrmps_pkg::HIST_W;
    localparam int QW     = qrmps_pkg::Q_W;
    localparam int CW     = $clog2(qrmps_pkg::Q_W);

    localparam logic [SW-1:0] MAX_SIDE_V = SW'(MAX_SIDE);
    localparam logic [SW-1:0] MIN_SIDE_V = SW'(qrmps_pkg::MIN_SIDE);

    function automatic logic [RW-1:0] close_term(input logic [RW-1:0] run);
        if (run >= RW'(qrmps_pkg::MIN_RUN))
            return run - RW'(qrmps_pkg::RUN_OFFSET);
        else
            return '0;
    endfunction

    function automatic logic is_finder(input logic [HW-1:0] w);
        return (w == qrmps_pkg::FINDER_LEAD) || (w == qrmps_pkg::FINDER_TRAIL);
    endfunction

    // configuration
    logic [SW-1:0]   side_eff_reg;
    logic [SQ_W-1:0] side_sq_reg;

    // column memory
    logic [ENT_W-1:0] col_mem [MAX_SIDE];
    logic [ENT_W-1:0] rd_reg;

    // scan position and pipeline stage
    logic [SW-1:0] x_pos_reg, y_pos_reg;
    logic          p_valid_reg, p_bit_reg, p_last_reg;
    logic [SW-1:0] p_x_reg, p_y_reg;

    // row state and sums
    logic [RW-1:0]                       row_run_reg;
    logic [HW-1:0]                       row_win_reg;
    logic                                prev_up_reg;
    logic [DARK_W-1:0]                   dark_reg;
    logic [qrmps_pkg::RUN_PEN_W-1:0]     run_sum_reg;
    logic [qrmps_pkg::BLOCK_PEN_W-1:0]   block_sum_reg;
    logic [qrmps_pkg::PATTERN_PEN_W-1:0] pattern_sum_reg;

    // divider
    qrmps_pkg::state_t state_reg, state_next;
    logic [DIV_W-1:0]  num_reg;
    logic [QW-1:0]     quot_reg;
    logic [CW-1:0]     cnt_reg;

    // output register
    logic                          m_valid_reg;
    logic [qrmps_pkg::OUT_DATA_W-1:0] m_data_reg;

    logic in_fire, cfg_fire, load_out;
    logic x_end, y_end;

    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid & cfg_ready;
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign x_end         = (x_pos_reg == side_eff_reg - SW'(1));
    assign y_end         = (y_pos_reg == side_eff_reg - SW'(1));

    // per-module compute on the item in the pipeline stage
    logic [HW-1:0] col_h, col_hist_new, row_win_new;
    logic [RW-1:0] col_run_old, col_run_new, row_run_new;
    logic          px_end, py_end, block_hit, row_pat, col_pat, bit_in;
    logic [RW+1:0] run_add;
    logic [qrmps_pkg::RUN_PEN_W+2:0]     run_sum_wide;
    logic [qrmps_pkg::BLOCK_PEN_W:0]     block_sum_wide;
    logic [qrmps_pkg::PATTERN_PEN_W:0]   pattern_sum_wide;
    logic [7:0]                          pattern_add;

    always_comb
    begin
        bit_in      = p_bit_reg;
        px_end      = (p_x_reg == side_eff_reg - SW'(1));
        py_end      = (p_y_reg == side_eff_reg - SW'(1));
        col_h       = (p_y_reg == '0) ? '0 : rd_reg[HW-1:0];
        col_run_old = rd_reg[ENT_W-1:HW];

        block_hit = (p_x_reg != '0) && (p_y_reg != '0) && (col_h[0] == bit_in)
                    && (prev_up_reg == bit_in) && (row_win_reg[0] == bit_in);

        run_add = '0;
        if (p_x_reg == '0)
        begin
            row_run_new = RW'(1);
        end
        else if (row_win_reg[0] == bit_in)
        begin
            row_run_new = row_run_reg + RW'(1);
        end
        else
        begin
            run_add     = run_add + (RW+2)'(close_term(row_run_reg));
            row_run_new = RW'(1);
        end
        if (px_end)
            run_add = run_add + (RW+2)'(close_term(row_run_new));
        row_win_new = {row_win_reg[HW-2:0], bit_in};
        row_pat     = (p_x_reg >= SW'(HW - 1)) && is_finder(row_win_new);

        if (p_y_reg == '0)
        begin
            col_run_new = RW'(1);
        end
        else if (col_h[0] == bit_in)
        begin
            col_run_new = col_run_old + RW'(1);
        end
        else
        begin
            run_add     = run_add + (RW+2)'(close_term(col_run_old));
            col_run_new = RW'(1);
        end
        if (py_end)
            run_add = run_add + (RW+2)'(close_term(col_run_new));
        col_hist_new = {col_h[HW-2:0], bit_in};
        col_pat      = (p_y_reg >= SW'(HW - 1)) && is_finder(col_hist_new);

        pattern_add = 8'((row_pat ? qrmps_pkg::PATTERN_SCORE : 0)
                         + (col_pat ? qrmps_pkg::PATTERN_SCORE : 0));

        run_sum_wide     = (qrmps_pkg::RUN_PEN_W+3)'(run_sum_reg)
                           + (qrmps_pkg::RUN_PEN_W+3)'(run_add);
        block_sum_wide   = (qrmps_pkg::BLOCK_PEN_W+1)'(block_sum_reg)
                           + (block_hit ? (qrmps_pkg::BLOCK_PEN_W+1)'(qrmps_pkg::BLOCK_SCORE)
                                        : '0);
        pattern_sum_wide = (qrmps_pkg::PATTERN_PEN_W+1)'(pattern_sum_reg)
                           + (qrmps_pkg::PATTERN_PEN_W+1)'(pattern_add);
    end

    // balance score and total from the divider result
    logic [QW-1:0]  k_adj, k_dist;
    logic [qrmps_pkg::BALANCE_PEN_W-1:0] balance_pen;
    logic [qrmps_pkg::TOTAL_PEN_W+1:0]   total_wide;
    logic [qrmps_pkg::TOTAL_PEN_W-1:0]   total_pen;
    logic [DIV_W-1:0] div_shift;
    logic             div_ge;

    always_comb
    begin
        if ((quot_reg < QW'(qrmps_pkg::HALF_STEPS)) && (num_reg != '0))
            k_adj = quot_reg + QW'(1);
        else
            k_adj = quot_reg;
        if (k_adj >= QW'(qrmps_pkg::HALF_STEPS))
            k_dist = k_adj - QW'(qrmps_pkg::HALF_STEPS);
        else
            k_dist = QW'(qrmps_pkg::HALF_STEPS) - k_adj;
        balance_pen = qrmps_pkg::BALANCE_PEN_W'(k_dist * qrmps_pkg::STEP_SCORE);
        total_wide  = (qrmps_pkg::TOTAL_PEN_W+2)'(run_sum_reg)
                      + (qrmps_pkg::TOTAL_PEN_W+2)'(block_sum_reg)
                      + (qrmps_pkg::TOTAL_PEN_W+2)'(pattern_sum_reg)
                      + (qrmps_pkg::TOTAL_PEN_W+2)'(balance_pen);
        if (total_wide > (qrmps_pkg::TOTAL_PEN_W+2)'({qrmps_pkg::TOTAL_PEN_W{1'b1}}))
            total_pen = '1;
        else
            total_pen = total_wide[qrmps_pkg::TOTAL_PEN_W-1:0];
        div_shift = DIV_W'(side_sq_reg) << cnt_reg;
        div_ge    = (num_reg >= div_shift);
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            qrmps_pkg::ST_SCAN:
            begin
                s_axis_tready = !(p_valid_reg && p_last_reg);
                if (p_valid_reg && p_last_reg)
                    state_next = qrmps_pkg::ST_DIV;
            end
            qrmps_pkg::ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = qrmps_pkg::ST_DONE;
            end
            qrmps_pkg::ST_DONE:
            begin
                load_out = !m_valid_reg || m_axis_tready;
                if (load_out)
                    state_next = qrmps_pkg::ST_SCAN;
            end
            default:
            begin
                state_next = qrmps_pkg::ST_SCAN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= qrmps_pkg::ST_SCAN;
        else if (cfg_fire)
            state_reg <= qrmps_pkg::ST_SCAN;
        else
            state_reg <= state_next;
    end

    // column memory: read on accept, write back from the pipeline stage
    always_ff @(posedge clk)
    begin
        if (p_valid_reg)
            col_mem[p_x_reg[AW-1:0]] <= {col_run_new, col_hist_new};
        if (in_fire)
            rd_reg <= col_mem[x_pos_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_eff_reg    <= MIN_SIDE_V;
            side_sq_reg     <= SQ_W'(qrmps_pkg::MIN_SIDE * qrmps_pkg::MIN_SIDE);
            x_pos_reg       <= '0;
            y_pos_reg       <= '0;
            p_valid_reg     <= 1'b0;
            p_bit_reg       <= 1'b0;
            p_last_reg      <= 1'b0;
            p_x_reg         <= '0;
            p_y_reg         <= '0;
            row_run_reg     <= '0;
            row_win_reg     <= '0;
            prev_up_reg     <= 1'b0;
            dark_reg        <= '0;
            run_sum_reg     <= '0;
            block_sum_reg   <= '0;
            pattern_sum_reg <= '0;
            num_reg         <= '0;
            quot_reg        <= '0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            side_sq_reg <= SQ_W'(side_eff_reg * side_eff_reg);

            if (cfg_fire)
            begin
                if (cfg_data < MIN_SIDE_V)
                    side_eff_reg <= MIN_SIDE_V;
                else if (cfg_data > MAX_SIDE_V)
                    side_eff_reg <= MAX_SIDE_V;
                else
                    side_eff_reg <= cfg_data;
                x_pos_reg       <= '0;
                y_pos_reg       <= '0;
                p_valid_reg     <= 1'b0;
                row_run_reg     <= '0;
                row_win_reg     <= '0;
                dark_reg        <= '0;
                run_sum_reg     <= '0;
                block_sum_reg   <= '0;
                pattern_sum_reg <= '0;
            end
            else
            begin
                p_valid_reg <= in_fire;
                if (in_fire)
                begin
                    p_bit_reg  <= s_axis_tdata[0];
                    p_x_reg    <= x_pos_reg;
                    p_y_reg    <= y_pos_reg;
                    p_last_reg <= x_end && y_end;
                    if (x_end)
                    begin
                        x_pos_reg <= '0;
                        y_pos_reg <= y_end ? '0 : y_pos_reg + SW'(1);
                    end
                    else
                    begin
                        x_pos_reg <= x_pos_reg + SW'(1);
                    end
                end

                if (p_valid_reg)
                begin
                    row_run_reg <= row_run_new;
                    row_win_reg <= row_win_new;
                    prev_up_reg <= col_h[0];
                    dark_reg    <= dark_reg + DARK_W'(bit_in);
                    run_sum_reg <= (run_sum_wide > (qrmps_pkg::RUN_PEN_W+3)'(
                                        {qrmps_pkg::RUN_PEN_W{1'b1}}))
                                   ? '1 : run_sum_wide[qrmps_pkg::RUN_PEN_W-1:0];
                    block_sum_reg <= block_sum_wide[qrmps_pkg::BLOCK_PEN_W]
                                     ? '1 : block_sum_wide[qrmps_pkg::BLOCK_PEN_W-1:0];
                    pattern_sum_reg <= pattern_sum_wide[qrmps_pkg::PATTERN_PEN_W]
                                       ? '1 : pattern_sum_wide[qrmps_pkg::PATTERN_PEN_W-1:0];
                    if (p_last_reg)
                    begin
                        num_reg  <= DIV_W'((dark_reg + DARK_W'(bit_in))
                                           * qrmps_pkg::STEP_COUNT);
                        quot_reg <= '0;
                        cnt_reg  <= CW'(QW - 1);
                    end
                end

                if (state_reg == qrmps_pkg::ST_DIV)
                begin
                    if (div_ge)
                    begin
                        num_reg           <= num_reg - div_shift;
                        quot_reg[cnt_reg] <= 1'b1;
                    end
                    if (cnt_reg != '0)
                        cnt_reg <= cnt_reg - CW'(1);
                end

                if (load_out)
                begin
                    row_run_reg     <= '0;
                    row_win_reg     <= '0;
                    dark_reg        <= '0;
                    run_sum_reg     <= '0;
                    block_sum_reg   <= '0;
                    pattern_sum_reg <= '0;
                end
            end

            if (load_out && !cfg_fire)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            m_data_reg <= qrmps_pkg::OUT_DATA_W'({total_pen, balance_pen, pattern_sum_reg,
                                                  block_sum_reg, run_sum_reg});
    end

    // checks
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (x_pos_reg < side_eff_reg) && (y_pos_reg < side_eff_reg))
        else $error("scan position outside symbol");

    a_no_accept_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && p_last_reg) |-> !s_axis_tready)
        else $error("module accepted while symbol is closing");

    a_quotient_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qrmps_pkg::ST_DONE) |-> (quot_reg <= QW'(qrmps_pkg::STEP_COUNT)))
        else $error("balance quotient out of range");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == qrmps_pkg::ST_DONE))
        else $error("result raised outside finish step");

    a_div_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && p_last_reg && !cfg_fire) |=> (state_reg == qrmps_pkg::ST_DIV))
        else $error("divider not started after last module");

endmodule

`default_nettype wire
